[rtl/core/cfa_pkg.sv]
// Types and constants shared by the contiguous fit allocator.
// No dependencies.
package cfa_pkg;

   localparam int ADDR_W = 16;
   localparam int ID_W   = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ADDR_W-1:0] RESET_TOTAL = 16'd1024;
   localparam logic [ADDR_W-1:0] SLICE_LIMIT = 16'd10;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_LARGE  = 3'd1,
      ST_ZERO_SIZE  = 3'd2,
      ST_NO_FIT     = 3'd3,
      ST_ID_UNKNOWN = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   localparam logic [1:0] POL_WORST = 2'd1;
   localparam logic [1:0] POL_FIRST = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY = 2'd1;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] req_size;
      logic [ID_W-1:0]   region_id;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] granted_size;
      logic [ID_W-1:0]   id_out;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } free_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } owned_entry_type;

endpackage

[rtl/core/cfa_ram.sv]
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module cfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/contiguous_fit_allocator_top.sv]
// Allocate, or release of an unknown id, scans the tables once in S_SCAN_A and then commits;
// release of an owned id also makes a second pass, S_SCAN_B, which looks for free neighbors.
// Throughput: one word at a time; busy stays high until the result is on rsp_data.
// Results are a one-cycle strobe, the receiver cannot stall.
// Reset: the S_INIT state writes the initial free extent, busy high meanwhile.
// Depends on cfa_pkg and cfa_ram.
module contiguous_fit_allocator_top #(
   parameter int OWNED_ENTRIES = 16,
   parameter int FREE_ENTRIES  = 17
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cfa_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output cfa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cfa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cfa_pkg::ADDR_W-1:0]          csr_wdata
);

   localparam int FIDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
   localparam int OIDX_W = (OWNED_ENTRIES > 1) ? $clog2(OWNED_ENTRIES) : 1;
   localparam int SCAN_N = (FREE_ENTRIES > OWNED_ENTRIES) ? FREE_ENTRIES : OWNED_ENTRIES;
   localparam int CNT_W  = $clog2(SCAN_N + 1);
   localparam int AW     = cfa_pkg::ADDR_W;
   localparam int IW     = cfa_pkg::ID_W;

   typedef enum logic [4:0] {
      S_INIT   = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN_A = 5'b00100,
      S_SCAN_B = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, pcnt_ff, pcnt_in;
   logic pvld_ff, pvld_in;
   cfa_pkg::req_type req_ff, req_in;
   logic [AW-1:0] total_ff, total_in;
   logic [1:0] pol_ff, pol_in;
   logic [IW-1:0] next_id_ff, next_id_in;
   logic [FREE_ENTRIES-1:0] free_valid_ff, free_valid_in;
   logic [OWNED_ENTRIES-1:0] owned_valid_ff, owned_valid_in;

   // allocate pass: chosen extent and first empty owned slot
   logic b_found_ff, b_found_in;
   logic [FIDX_W-1:0] b_idx_ff, b_idx_in;
   logic [AW-1:0] b_start_ff, b_start_in, b_len_ff, b_len_in;
   logic os_found_ff, os_found_in;
   logic [OIDX_W-1:0] os_idx_ff, os_idx_in;
   // release passes: owned hit, left and right neighbors, first empty free slot
   logic r_found_ff, r_found_in;
   logic [OIDX_W-1:0] r_slot_ff, r_slot_in;
   logic [AW-1:0] r_start_ff, r_start_in, r_len_ff, r_len_in;
   logic l_found_ff, l_found_in;
   logic [FIDX_W-1:0] l_idx_ff, l_idx_in;
   logic [AW-1:0] l_start_ff, l_start_in, l_len_ff, l_len_in;
   logic rr_found_ff, rr_found_in;
   logic [FIDX_W-1:0] rr_idx_ff, rr_idx_in;
   logic [AW-1:0] rr_len_ff, rr_len_in;
   logic ff_found_ff, ff_found_in;
   logic [FIDX_W-1:0] ff_idx_ff, ff_idx_in;

   logic rsp_valid_ff, rsp_valid_in;
   cfa_pkg::rsp_type rsp_ff, rsp_in;

   logic fw_en, ow_en;
   logic [FIDX_W-1:0] fw_addr;
   logic [OIDX_W-1:0] ow_addr;
   cfa_pkg::free_entry_type fw_data, f_rd;
   cfa_pkg::owned_entry_type ow_data, o_rd;

   cfa_ram #(.WIDTH($bits(cfa_pkg::free_entry_type)), .DEPTH(FREE_ENTRIES)) u_free_ram (
      .clock   (clock),
      .wr_en   (fw_en),
      .wr_addr (fw_addr),
      .wr_data (fw_data),
      .rd_addr (cnt_ff[FIDX_W-1:0]),
      .rd_data (f_rd)
   );

   cfa_ram #(.WIDTH($bits(cfa_pkg::owned_entry_type)), .DEPTH(OWNED_ENTRIES)) u_owned_ram (
      .clock   (clock),
      .wr_en   (ow_en),
      .wr_addr (ow_addr),
      .wr_data (ow_data),
      .rd_addr (cnt_ff[OIDX_W-1:0]),
      .rd_data (o_rd)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) || (state_ff == S_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic f_hit, o_hit, fv, ov, take, scan_end;
      logic [AW:0] f_end, r_end;
      logic [IW-1:0] nid;
      logic [AW-1:0] left, gsize;
      logic [FIDX_W-1:0] fidx;
      logic [OIDX_W-1:0] oidx;

      state_in = state_ff;
      cnt_in = cnt_ff;
      pvld_in = 1'b0;
      pcnt_in = cnt_ff;
      req_in = req_ff;
      total_in = total_ff;
      pol_in = pol_ff;
      next_id_in = next_id_ff;
      free_valid_in = free_valid_ff;
      owned_valid_in = owned_valid_ff;
      b_found_in = b_found_ff; b_idx_in = b_idx_ff;
      b_start_in = b_start_ff; b_len_in = b_len_ff;
      os_found_in = os_found_ff; os_idx_in = os_idx_ff;
      r_found_in = r_found_ff; r_slot_in = r_slot_ff;
      r_start_in = r_start_ff; r_len_in = r_len_ff;
      l_found_in = l_found_ff; l_idx_in = l_idx_ff;
      l_start_in = l_start_ff; l_len_in = l_len_ff;
      rr_found_in = rr_found_ff; rr_idx_in = rr_idx_ff; rr_len_in = rr_len_ff;
      ff_found_in = ff_found_ff; ff_idx_in = ff_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      fw_en = 1'b0; fw_addr = '0; fw_data = '0;
      ow_en = 1'b0; ow_addr = '0; ow_data = '0;

      fidx = pcnt_ff[FIDX_W-1:0];
      oidx = pcnt_ff[OIDX_W-1:0];
      f_hit = pvld_ff && (pcnt_ff < CNT_W'(FREE_ENTRIES));
      o_hit = pvld_ff && (pcnt_ff < CNT_W'(OWNED_ENTRIES));
      fv = f_hit && free_valid_ff[fidx];
      ov = o_hit && owned_valid_ff[oidx];
      f_end = {1'b0, f_rd.start} + {1'b0, f_rd.len};
      r_end = {1'b0, r_start_ff} + {1'b0, r_len_ff};
      scan_end = (cnt_ff == CNT_W'(SCAN_N));
      nid = next_id_ff + IW'(1);
      if (nid == '0) begin
         nid = IW'(1);
      end
      left = b_len_ff - req_ff.req_size;
      gsize = req_ff.req_size;
      take = 1'b0;

      case (state_ff)
         S_INIT: begin
            fw_en = 1'b1;
            fw_data.len = total_ff;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               cnt_in = '0;
               b_found_in = 1'b0; os_found_in = 1'b0; r_found_in = 1'b0;
               l_found_in = 1'b0; rr_found_in = 1'b0; ff_found_in = 1'b0;
               state_in = S_SCAN_A;
            end
         end
         S_SCAN_A: begin
            if (req_ff.op == cfa_pkg::OP_ALLOC) begin
               if (pol_ff == cfa_pkg::POL_WORST) begin
                  take = fv && (!b_found_ff || f_rd.len > b_len_ff ||
                         (f_rd.len == b_len_ff && f_rd.start < b_start_ff));
               end else if (pol_ff == cfa_pkg::POL_FIRST) begin
                  take = fv && f_rd.len >= req_ff.req_size &&
                         (!b_found_ff || f_rd.start < b_start_ff);
               end else begin
                  take = fv && f_rd.len >= req_ff.req_size &&
                         (!b_found_ff || f_rd.len < b_len_ff ||
                         (f_rd.len == b_len_ff && f_rd.start < b_start_ff));
               end
               if (take) begin
                  b_found_in = 1'b1; b_idx_in = fidx;
                  b_start_in = f_rd.start; b_len_in = f_rd.len;
               end
               if (o_hit && !owned_valid_ff[oidx] && !os_found_ff) begin
                  os_found_in = 1'b1; os_idx_in = oidx;
               end
            end else begin
               if (ov && req_ff.region_id != '0 && o_rd.id == req_ff.region_id &&
                   !r_found_ff) begin
                  r_found_in = 1'b1; r_slot_in = oidx;
                  r_start_in = o_rd.start; r_len_in = o_rd.len;
               end
            end
            if (scan_end) begin
               cnt_in = '0;
               if (req_ff.op == cfa_pkg::OP_RELEASE && r_found_in) begin
                  state_in = S_SCAN_B;
               end else begin
                  state_in = S_COMMIT;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               pvld_in = 1'b1;
            end
         end
         S_SCAN_B: begin
            if (fv && f_end == {1'b0, r_start_ff}) begin
               l_found_in = 1'b1; l_idx_in = fidx;
               l_start_in = f_rd.start; l_len_in = f_rd.len;
            end
            if (fv && {1'b0, f_rd.start} == r_end) begin
               rr_found_in = 1'b1; rr_idx_in = fidx; rr_len_in = f_rd.len;
            end
            if (f_hit && !free_valid_ff[fidx] && !ff_found_ff) begin
               ff_found_in = 1'b1; ff_idx_in = fidx;
            end
            if (scan_end) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               pvld_in = 1'b1;
            end
         end
         S_COMMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            state_in = S_IDLE;
            if (req_ff.op == cfa_pkg::OP_ALLOC) begin
               if (req_ff.req_size > total_ff) begin
                  rsp_in.status = cfa_pkg::ST_TOO_LARGE;
               end else if (req_ff.req_size == '0) begin
                  rsp_in.status = cfa_pkg::ST_ZERO_SIZE;
               end else if (!os_found_ff) begin
                  rsp_in.status = cfa_pkg::ST_TABLE_FULL;
               end else if (!b_found_ff || b_len_ff < req_ff.req_size) begin
                  rsp_in.status = cfa_pkg::ST_NO_FIT;
               end else begin
                  if (left <= cfa_pkg::SLICE_LIMIT) begin
                     // small leftover is absorbed into the grant
                     gsize = b_len_ff;
                     free_valid_in[b_idx_ff] = 1'b0;
                  end else begin
                     fw_en = 1'b1;
                     fw_addr = b_idx_ff;
                     fw_data.start = b_start_ff + req_ff.req_size;
                     fw_data.len = left;
                  end
                  ow_en = 1'b1;
                  ow_addr = os_idx_ff;
                  ow_data.id = nid;
                  ow_data.start = b_start_ff;
                  ow_data.len = gsize;
                  owned_valid_in[os_idx_ff] = 1'b1;
                  next_id_in = nid;
                  rsp_in.status = cfa_pkg::ST_OK;
                  rsp_in.base_addr = b_start_ff;
                  rsp_in.granted_size = gsize;
                  rsp_in.id_out = nid;
               end
            end else begin
               if (!r_found_ff) begin
                  rsp_in.status = cfa_pkg::ST_ID_UNKNOWN;
               end else begin
                  owned_valid_in[r_slot_ff] = 1'b0;
                  fw_en = 1'b1;
                  if (l_found_ff) begin
                     // left neighbor absorbs region and right neighbor if any
                     fw_addr = l_idx_ff;
                     fw_data.start = l_start_ff;
                     fw_data.len = l_len_ff + r_len_ff + (rr_found_ff ? rr_len_ff : '0);
                     if (rr_found_ff) begin
                        free_valid_in[rr_idx_ff] = 1'b0;
                     end
                  end else if (rr_found_ff) begin
                     fw_addr = rr_idx_ff;
                     fw_data.start = r_start_ff;
                     fw_data.len = r_len_ff + rr_len_ff;
                  end else begin
                     fw_addr = ff_idx_ff;
                     fw_data.start = r_start_ff;
                     fw_data.len = r_len_ff;
                     fw_en = ff_found_ff;
                     if (ff_found_ff) begin
                        free_valid_in[ff_idx_ff] = 1'b1;
                     end
                  end
                  rsp_in.status = cfa_pkg::ST_OK;
                  rsp_in.base_addr = r_start_ff;
                  rsp_in.granted_size = r_len_ff;
                  rsp_in.id_out = req_ff.region_id;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration words, taken only while idle (or during init)
      if (csr_valid && csr_ready) begin
         if (csr_index == cfa_pkg::CSR_TOTAL_SIZE) begin
            total_in = csr_wdata;
            free_valid_in = '0;
            free_valid_in[0] = (csr_wdata != '0);
            owned_valid_in = '0;
            fw_en = 1'b1;
            fw_addr = '0;
            fw_data.start = '0;
            fw_data.len = csr_wdata;
         end else if (csr_index == cfa_pkg::CSR_FIT_POLICY) begin
            pol_in = csr_wdata[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pvld_ff <= 1'b0;
         cnt_ff <= '0;
         total_ff <= cfa_pkg::RESET_TOTAL;
         pol_ff <= '0;
         next_id_ff <= '0;
         free_valid_ff <= FREE_ENTRIES'(1);
         owned_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff <= pvld_in;
         cnt_ff <= cnt_in;
         total_ff <= total_in;
         pol_ff <= pol_in;
         next_id_ff <= next_id_in;
         free_valid_ff <= free_valid_in;
         owned_valid_ff <= owned_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcnt_ff <= pcnt_in;
      req_ff <= req_in;
      b_found_ff <= b_found_in; b_idx_ff <= b_idx_in;
      b_start_ff <= b_start_in; b_len_ff <= b_len_in;
      os_found_ff <= os_found_in; os_idx_ff <= os_idx_in;
      r_found_ff <= r_found_in; r_slot_ff <= r_slot_in;
      r_start_ff <= r_start_in; r_len_ff <= r_len_in;
      l_found_ff <= l_found_in; l_idx_ff <= l_idx_in;
      l_start_ff <= l_start_in; l_len_ff <= l_len_in;
      rr_found_ff <= rr_found_in; rr_idx_ff <= rr_idx_in; rr_len_ff <= rr_len_in;
      ff_found_ff <= ff_found_in; ff_idx_ff <= ff_idx_in;
      rsp_ff <= rsp_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != cfa_pkg::ST_OK) |->
      (rsp_data.base_addr == '0 && rsp_data.granted_size == '0 && rsp_data.id_out == '0))
      else $error("error result carries payload");

   a_ok_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cfa_pkg::ST_OK) |->
      (rsp_data.id_out != '0 && rsp_data.granted_size != '0))
      else $error("ok result with zero id or size");

endmodule

[dv/contiguous_fit_allocator_top_tb.sv]
// Self-checking testbench for contiguous_fit_allocator_top: directed and random allocate and
// release words are checked against an in-bench predictor of the free and owned tables.
// Depends on cfa_pkg and the allocator RTL.
module contiguous_fit_allocator_top_tb;

   localparam int OWNED_N = 16;
   localparam int FREE_N  = 17;
   localparam logic [1:0] POL_BEST  = 2'd0;
   localparam logic [1:0] POL_ALIAS = 2'd3;   // unused encoding, behaves as best fit

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   cfa_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   cfa_pkg::rsp_type                    rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [cfa_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [cfa_pkg::ADDR_W-1:0]          csr_wdata = '0;

   contiguous_fit_allocator_top #(.OWNED_ENTRIES(OWNED_N), .FREE_ENTRIES(FREE_N)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   int unsigned pool_total;
   logic [1:0]  pool_policy;
   int unsigned last_id;
   int unsigned ext_start [FREE_N];
   int unsigned ext_len   [FREE_N];
   bit          ext_valid [FREE_N];
   int unsigned reg_id    [OWNED_N];
   int unsigned reg_start [OWNED_N];
   int unsigned reg_len   [OWNED_N];
   bit          reg_valid [OWNED_N];

   cfa_pkg::rsp_type pending_grants[$];
   int      mismatches = 0;
   bit      no_gaps = 1'b0;

   function void clear_tables();
      for (int i = 0; i < FREE_N; i++) begin
         ext_start[i] = 0; ext_len[i] = 0; ext_valid[i] = 1'b0;
      end
      for (int i = 0; i < OWNED_N; i++) reg_valid[i] = 1'b0;
      ext_len[0] = pool_total;
      ext_valid[0] = pool_total != 0;
   endfunction

   function void merge_extents();
      bit changed;
      changed = 1'b1;
      for (int i = 0; i < FREE_N; i++)
         if (ext_valid[i] && ext_len[i] == 0) ext_valid[i] = 1'b0;
      while (changed) begin
         changed = 1'b0;
         for (int i = 0; i < FREE_N; i++) begin
            if (!ext_valid[i]) continue;
            for (int j = 0; j < FREE_N; j++) begin
               if (j == i || !ext_valid[j]) continue;
               if (ext_start[i] + ext_len[i] == ext_start[j]) begin
                  ext_len[i] += ext_len[j];
                  ext_valid[j] = 1'b0;
                  changed = 1'b1;
               end
            end
         end
      end
   endfunction

   function int choose_extent(int unsigned need);
      int pick;
      pick = -1;
      for (int i = 0; i < FREE_N; i++) begin
         if (!ext_valid[i]) continue;
         if (pool_policy == cfa_pkg::POL_WORST) begin
            if (pick < 0 || ext_len[i] > ext_len[pick] ||
                (ext_len[i] == ext_len[pick] && ext_start[i] < ext_start[pick]))
               pick = i;
         end else begin
            if (ext_len[i] < need) continue;
            if (pick < 0) pick = i;
            else if (pool_policy == cfa_pkg::POL_FIRST) begin
               if (ext_start[i] < ext_start[pick]) pick = i;
            end else if (ext_len[i] < ext_len[pick] ||
                         (ext_len[i] == ext_len[pick] && ext_start[i] < ext_start[pick]))
               pick = i;
         end
      end
      if (pick >= 0 && ext_len[pick] < need) pick = -1;
      return pick;
   endfunction

   function void give_back(int unsigned s, int unsigned n);
      for (int i = 0; i < FREE_N; i++) begin
         if (!ext_valid[i]) continue;
         if (ext_start[i] + ext_len[i] == s) begin
            ext_len[i] += n;
            return;
         end
         if (s + n == ext_start[i]) begin
            ext_start[i] = s;
            ext_len[i] += n;
            return;
         end
      end
      for (int i = 0; i < FREE_N; i++)
         if (!ext_valid[i]) begin
            ext_valid[i] = 1'b1; ext_start[i] = s; ext_len[i] = n;
            return;
         end
   endfunction

   function cfa_pkg::rsp_type predict_grant(cfa_pkg::req_type w);
      cfa_pkg::rsp_type r;
      int          slot, e;
      int unsigned need;
      r = '0;
      r.status = cfa_pkg::ST_OK;
      slot = -1;
      if (w.op == cfa_pkg::OP_ALLOC) begin
         need = 32'(w.req_size);
         for (int i = 0; i < OWNED_N; i++)
            if (!reg_valid[i]) begin slot = i; break; end
         if (need > pool_total) r.status = cfa_pkg::ST_TOO_LARGE;
         else if (need == 0) r.status = cfa_pkg::ST_ZERO_SIZE;
         else if (slot < 0) r.status = cfa_pkg::ST_TABLE_FULL;
         else begin
            e = choose_extent(need);
            if (e < 0) r.status = cfa_pkg::ST_NO_FIT;
            else begin
               r.base_addr = 16'(ext_start[e]);
               if (ext_len[e] - need <= 32'(cfa_pkg::SLICE_LIMIT)) begin
                  r.granted_size = 16'(ext_len[e]);
                  ext_valid[e] = 1'b0; ext_len[e] = 0; ext_start[e] = 0;
               end else begin
                  r.granted_size = 16'(need);
                  ext_start[e] = (ext_start[e] + need) & 16'hFFFF;
                  ext_len[e] -= need;
               end
               last_id = (last_id + 1) & 16'hFFFF;
               if (last_id == 0) last_id = 1;
               r.id_out = 16'(last_id);
               reg_valid[slot] = 1'b1;
               reg_id[slot] = last_id;
               reg_start[slot] = 32'(r.base_addr);
               reg_len[slot] = 32'(r.granted_size);
            end
         end
      end else begin
         if (w.region_id != 0)
            for (int i = 0; i < OWNED_N; i++)
               if (reg_valid[i] && reg_id[i] == 32'(w.region_id)) begin slot = i; break; end
         if (slot < 0) r.status = cfa_pkg::ST_ID_UNKNOWN;
         else begin
            r.base_addr = 16'(reg_start[slot]);
            r.granted_size = 16'(reg_len[slot]);
            r.id_out = w.region_id;
            reg_valid[slot] = 1'b0;
            give_back(reg_start[slot], reg_len[slot]);
         end
      end
      merge_extents();
      return r;
   endfunction

   // start is left high after acceptance so a following word goes back to back, unless a random gap drops it
   task automatic send_word(input cfa_pkg::op_type op, input int unsigned size,
                            input int unsigned id);
      cfa_pkg::req_type w;
      int      gap;
      w.op = op;
      w.req_size = size[15:0];
      w.region_id = id[15:0];
      req_data <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_grants.push_back(predict_grant(w));
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [cfa_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned val);
      wait_idle();
      csr_index <= idx;
      csr_wdata <= val[15:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == cfa_pkg::CSR_TOTAL_SIZE) begin
         pool_total = val & 16'hFFFF;
         clear_tables();
      end else if (idx == cfa_pkg::CSR_FIT_POLICY) pool_policy = val[1:0];
   endtask

   function int unsigned some_owned_id();
      int unsigned ids[$];
      for (int i = 0; i < OWNED_N; i++) if (reg_valid[i]) ids.push_back(reg_id[i]);
      if (ids.size() == 0) return $urandom_range(0, 65535);
      return ids[$urandom_range(0, ids.size() - 1)];
   endfunction

   function void note_mismatch(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d got %0d", field, want, got);
   endfunction

   always @(posedge clock) begin
      cfa_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0)
            note_mismatch("unexpected word", 0, 32'(rsp_data.id_out));
         else begin
            want = pending_grants.pop_front();
            if (rsp_data.status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.base_addr !== want.base_addr)
               note_mismatch("base_addr", 32'(want.base_addr), 32'(rsp_data.base_addr));
            if (rsp_data.granted_size !== want.granted_size)
               note_mismatch("granted_size", 32'(want.granted_size),
                             32'(rsp_data.granted_size));
            if (rsp_data.id_out !== want.id_out)
               note_mismatch("id_out", 32'(want.id_out), 32'(rsp_data.id_out));
         end
      end
   end

   task automatic test_status_codes();
      send_word(cfa_pkg::OP_ALLOC, 0, 0);
      send_word(cfa_pkg::OP_ALLOC, 1025, 0);
      send_word(cfa_pkg::OP_ALLOC, 65535, 65535);
      send_word(cfa_pkg::OP_ALLOC, 1024, 0);
      send_word(cfa_pkg::OP_ALLOC, 1, 0);             // no room left
      send_word(cfa_pkg::OP_RELEASE, 0, 1);
      send_word(cfa_pkg::OP_RELEASE, 0, 0);
      send_word(cfa_pkg::OP_RELEASE, 65535, 65535);
      send_word(cfa_pkg::OP_ALLOC, 1014, 0);          // leftover at the slice limit is absorbed
      send_word(cfa_pkg::OP_RELEASE, 0, last_id);
      send_word(cfa_pkg::OP_ALLOC, 1013, 0);          // one past the limit is carved
      send_word(cfa_pkg::OP_RELEASE, 0, last_id);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < OWNED_N + 1; i++) send_word(cfa_pkg::OP_ALLOC, 3, 0);
      for (int i = 0; i < OWNED_N; i += 2) send_word(cfa_pkg::OP_RELEASE, 0, last_id - i);
      for (int i = 1; i < OWNED_N; i += 2) send_word(cfa_pkg::OP_RELEASE, 0, last_id - i);
   endtask

   task automatic test_policies();
      int unsigned first;
      for (int p = 0; p < 4; p++) begin
         csr_write(cfa_pkg::CSR_TOTAL_SIZE, 100);
         csr_write(cfa_pkg::CSR_FIT_POLICY, p);
         send_word(cfa_pkg::OP_ALLOC, 20, 0);
         first = last_id;
         send_word(cfa_pkg::OP_ALLOC, 12, 0);
         send_word(cfa_pkg::OP_ALLOC, 30, 0);
         send_word(cfa_pkg::OP_ALLOC, 12, 0);
         send_word(cfa_pkg::OP_RELEASE, 0, first);
         send_word(cfa_pkg::OP_RELEASE, 0, first + 2);
         send_word(cfa_pkg::OP_ALLOC, 15, 0);
         send_word(cfa_pkg::OP_ALLOC, 27, 0);
      end
      csr_write(cfa_pkg::CSR_FIT_POLICY, POL_BEST);
   endtask

   task automatic test_total_extremes();
      csr_write(cfa_pkg::CSR_TOTAL_SIZE, 65535);
      send_word(cfa_pkg::OP_ALLOC, 65535, 0);
      send_word(cfa_pkg::OP_RELEASE, 0, last_id);
      csr_write(cfa_pkg::CSR_TOTAL_SIZE, 1);
      send_word(cfa_pkg::OP_ALLOC, 2, 0);
      send_word(cfa_pkg::OP_ALLOC, 1, 0);
      csr_write(cfa_pkg::CSR_TOTAL_SIZE, 0);          // empty pool
      send_word(cfa_pkg::OP_ALLOC, 0, 0);
      send_word(cfa_pkg::OP_ALLOC, 1, 0);
      csr_write(cfa_pkg::CSR_TOTAL_SIZE, 1024);
   endtask

   task automatic test_random();
      int          pick;
      int unsigned top;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: csr_write(cfa_pkg::CSR_TOTAL_SIZE, 65535);
            1: csr_write(cfa_pkg::CSR_TOTAL_SIZE, 1);
            2: csr_write(cfa_pkg::CSR_TOTAL_SIZE, 64);
            default: csr_write(cfa_pkg::CSR_TOTAL_SIZE, $urandom_range(16, 4096));
         endcase
         csr_write(cfa_pkg::CSR_FIT_POLICY, $urandom_range(0, 3));
         if (phase == 5) no_gaps = 1'b1;
         for (int n = 0; n < 110; n++) begin
            pick = $urandom_range(0, 99);
            top = pool_total / 6;
            if (top < 1) top = 1;
            if (pick < 50)
               send_word(cfa_pkg::OP_ALLOC, $urandom_range(1, top), $urandom_range(0, 65535));
            else if (pick < 55) send_word(cfa_pkg::OP_ALLOC, $urandom_range(0, 65535), 0);
            else if (pick < 58)
               send_word(cfa_pkg::OP_ALLOC, (pick == 55) ? 0 : pool_total + (pick - 56), 0);
            else if (pick < 90)
               send_word(cfa_pkg::OP_RELEASE, $urandom_range(0, 65535), some_owned_id());
            else send_word(cfa_pkg::OP_RELEASE, 0, $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      pool_total = 32'(cfa_pkg::RESET_TOTAL);
      pool_policy = POL_BEST;
      last_id = 0;
      clear_tables();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_status_codes();
      test_table_full();
      test_policies();
      test_total_extremes();
      csr_write(cfa_pkg::CSR_FIT_POLICY, POL_ALIAS);
      test_random();
      wait_idle();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_grants.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
rtl/core/cfa_pkg.sv
rtl/core/cfa_ram.sv
rtl/core/contiguous_fit_allocator_top.sv
dv/contiguous_fit_allocator_top_tb.sv
